### hw/rtl/ordered_array_list_macros.svh
// Assertion macros shared by the ordered array list RTL.
`ifndef ORDERED_ARRAY_LIST_MACROS_SVH
`define ORDERED_ARRAY_LIST_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OAL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered_array_list: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define OAL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered_array_list: assertion failed");

`endif

### hw/rtl/oal_pkg.sv
// Types and command codes for the ordered array list.
`timescale 1ns / 1ps
package oal_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_LOCATE = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [6:0]         position;
    logic signed [31:0] value;
  } oal_in_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] elem;
    logic [6:0]         found_pos;
    logic [6:0]         count;
  } oal_out_t;

  typedef struct packed {
    logic               ins;
    logic               del;
    logic               rd;
    logic [6:0]         position;
    logic signed [31:0] value;
  } oal_ctrl_t;

  typedef struct packed {
    logic               tok;
    logic               found;
    logic [6:0]         pos;
    logic signed [31:0] elem;
  } oal_carry_t;

endpackage

### hw/rtl/oal_cell.sv
// One storage cell of the list chain: holds one entry and one stage of the scan carrier.
`timescale 1ns / 1ps
module oal_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  oal_pkg::oal_ctrl_t  ctrl,
  input  logic [CW-1:0]       count,
  input  logic signed [31:0]  left_data,
  input  logic signed [31:0]  right_data,
  input  oal_pkg::oal_carry_t carry_i,
  output oal_pkg::oal_carry_t carry_o,
  output logic signed [31:0]  data_o
);
  import oal_pkg::*;

  localparam int PW = (CW > 7) ? CW : 7;
  localparam logic [PW:0] MY_POS = (PW + 1)'(IDX + 1);
  localparam logic [6:0]  MY_POS7 = 7'(IDX + 1);

  logic signed [31:0] data_r, data_nxt;
  oal_carry_t         carry_r, carry_nxt;
  logic [PW:0]        pos_w;
  logic               live, hit;

  assign pos_w = (PW + 1)'(ctrl.position);
  assign live  = CW'(IDX) < count;
  assign hit   = carry_i.tok && live &&
                 (ctrl.rd ? (pos_w == MY_POS) : (data_r == ctrl.value));

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (MY_POS > pos_w) begin
        data_nxt = left_data;
      end else if (MY_POS == pos_w) begin
        data_nxt = ctrl.value;
      end
    end else if (ctrl.del && (MY_POS >= pos_w)) begin
      data_nxt = right_data;
    end
  end

  always_comb begin
    carry_nxt     = carry_r;
    carry_nxt.tok = carry_i.tok;
    if (carry_i.tok) begin
      carry_nxt = carry_i;
      if (!carry_i.found && hit) begin
        carry_nxt.found = 1'b1;
        carry_nxt.pos   = ctrl.rd ? 7'd0 : MY_POS7;
        carry_nxt.elem  = ctrl.rd ? data_r : 32'sd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      carry_r <= '0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  assign carry_o = carry_r;
  assign data_o  = data_r;

endmodule

### hw/rtl/ordered_array_list.sv
// Top level of the ordered array list: command control, entry count and the cell chain.
`timescale 1ns / 1ps
// Ordered list of up to DEPTH signed 32-bit entries held one per cell in a chain.
// Insert and delete shift every later cell by one place at the accept edge and offer
// their transaction in the cycle after the accept cycle, so they can follow back to back.
// Read and locate send a token down the chain one cell per cycle, so their transaction
// is offered once the token has passed start_r, every cell and the done state; a stalled
// output waits there. A new command is taken only once the previous one has finished
// and the output register is free or draining. No clearing pass is needed after reset.
module ordered_array_list #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  oal_pkg::oal_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output oal_pkg::oal_out_t out_data
);
  import oal_pkg::*;

  `include "ordered_array_list_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 7) ? CW : 7;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  oal_out_t           out_r, out_nxt;
  logic               start_r, start_nxt;
  logic               lat_rd_r;
  logic [6:0]         lat_pos_r;
  logic signed [31:0] lat_val_r;

  logic               accept, out_free, ok_ins, ok_del, is_scan;
  logic [PW:0]        pos_w, cnt_w;
  oal_ctrl_t          ctrl;
  oal_carry_t         carry [DEPTH+1];
  logic signed [31:0] data_w [DEPTH];
  logic [DEPTH-1:0]   tok_vec;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign is_scan  = (in_data.cmd == CMD_READ) || (in_data.cmd == CMD_LOCATE);

  assign pos_w  = (PW + 1)'(in_data.position);
  assign cnt_w  = (PW + 1)'(count_r);
  assign ok_ins = (pos_w != '0) && (pos_w <= cnt_w + 1'b1) && (count_r < CW'(DEPTH));
  assign ok_del = (pos_w != '0) && (pos_w <= cnt_w);

  always_comb begin
    ctrl.ins      = accept && (in_data.cmd == CMD_INSERT) && ok_ins;
    ctrl.del      = accept && (in_data.cmd == CMD_DELETE) && ok_del;
    ctrl.rd       = lat_rd_r;
    ctrl.position = (state_r == ST_IDLE) ? in_data.position : lat_pos_r;
    ctrl.value    = (state_r == ST_IDLE) ? in_data.value : lat_val_r;
  end

  assign carry[0] = '{tok: start_r, found: 1'b0, pos: 7'd0, elem: 32'sd0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = ctrl.value;
    end else begin : g_mid
      assign left_d = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = data_w[i];
    end else begin : g_inner
      assign right_d = data_w[i+1];
    end
    oal_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .count      (count_r),
      .left_data  (left_d),
      .right_data (right_d),
      .carry_i    (carry[i]),
      .carry_o    (carry[i+1]),
      .data_o     (data_w[i])
    );
    assign tok_vec[i] = carry[i+1].tok;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    start_nxt     = 1'b0;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (is_scan) begin
            start_nxt = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            if (ctrl.ins) begin
              count_nxt = count_r + 1'b1;
            end else if (ctrl.del) begin
              count_nxt = count_r - 1'b1;
            end
            out_nxt.ok        = ctrl.ins || ctrl.del;
            out_nxt.elem      = 32'sd0;
            out_nxt.found_pos = 7'd0;
            out_nxt.count     = 7'(count_nxt);
            out_valid_nxt     = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (carry[DEPTH].tok) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_nxt.ok        = carry[DEPTH].found;
          out_nxt.elem      = carry[DEPTH].elem;
          out_nxt.found_pos = carry[DEPTH].pos;
          out_nxt.count     = 7'(count_r);
          out_valid_nxt     = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (accept) begin
      lat_rd_r  <= (in_data.cmd == CMD_READ);
      lat_pos_r <= in_data.position;
      lat_val_r <= in_data.value;
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      start_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= start_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `OAL_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `OAL_ASSERT_IMP(a_one_token, 1'b1, $onehot0({tok_vec, start_r}))
  `OAL_ASSERT_IMP(a_ready_idle, in_ready, state_r == ST_IDLE && tok_vec == '0 && !start_r)
  `OAL_ASSERT_NXT(a_ins_count, ctrl.ins, count_r == $past(count_r) + 1'b1 && out_valid_r)

endmodule
